// File: sv/assert_macros.svh
// Assertion macros for the dense ID table.
// Used by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: sv/dit_pkg.sv
// Shared constants and types for the dense ID table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dit_pkg;
	localparam int MAX_ROWS = 256;
	localparam int ID_W     = 32;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int CNT_W    = $clog2(MAX_ROWS + 1);
	localparam int CAP_W    = 9;
	localparam int IDX_W    = 8;
	localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef struct packed {
		logic            shift;
		logic [ID_W-1:0] tail_id;
	} ring_ctl_t;
endpackage
`default_nettype wire

// File: sv/dit_cell.sv
// One storage cell of the rotating ID ring.
// Depends on dit_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dit_cell (
	input  logic                     clk,
	input  logic                     shift,
	input  logic [dit_pkg::ID_W-1:0] nbr_id,
	output logic [dit_pkg::ID_W-1:0] id
);
	logic [dit_pkg::ID_W-1:0] id_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			id_q <= nbr_id;
		end
	end

	assign id = id_q;
endmodule
`default_nettype wire

// File: sv/dit_ctrl.sv
// Command sequencer: drives one full ring rotation per transaction,
// searches/reads at the ring head and injects writes at the tail.
// Depends on dit_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dit_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [dit_pkg::CAP_W-1:0]   cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  cmd,
	input  logic [31:0]                 entity_id,
	input  logic [dit_pkg::IDX_W-1:0]   row_index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic                        moved_valid,
	output logic [31:0]                 moved_id,
	output logic [31:0]                 read_id,
	output logic [8:0]                  live_count,
	output logic                        is_full,
	input  logic [dit_pkg::ID_W-1:0]    head_id,
	output dit_pkg::ring_ctl_t          ring_ctl
);
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t                        state_q;
	logic [dit_pkg::CAP_W-1:0]     cap_q;
	logic [dit_pkg::CNT_W-1:0]     count_q;
	logic [dit_pkg::ROW_W-1:0]     step_q;
	dit_pkg::cmd_t                 cmd_q;
	logic [dit_pkg::ID_W-1:0]      id_q;
	logic [dit_pkg::IDX_W-1:0]     row_q;
	logic [dit_pkg::ID_W-1:0]      last_q;
	logic [dit_pkg::ID_W-1:0]      prev_q;
	logic [dit_pkg::ID_W-1:0]      read_q;
	logic                          found_q;
	logic                          hit_last_q;
	logic                          hit_prev_q;

	logic                          out_valid_q;
	dit_pkg::status_t              status_q;
	logic                          moved_valid_q;
	logic [dit_pkg::ID_W-1:0]      moved_id_q;
	logic [dit_pkg::ID_W-1:0]      read_id_q;
	logic [dit_pkg::CNT_W-1:0]     live_count_q;
	logic                          is_full_q;

	logic [dit_pkg::CMP_W-1:0]     limit;
	logic [dit_pkg::CMP_W-1:0]     count_x;
	logic [dit_pkg::CMP_W-1:0]     step_x;
	logic [dit_pkg::CMP_W-1:0]     row_x;
	logic                          add_ok;
	logic                          in_rows;
	logic                          is_hit;
	logic                          add_slot;
	logic                          last_step;
	logic                          out_free;
	logic                          accept;

	dit_pkg::status_t              r_status;
	logic                          r_moved_valid;
	logic [dit_pkg::ID_W-1:0]      r_moved_id;
	logic [dit_pkg::ID_W-1:0]      r_read_id;
	logic [dit_pkg::CNT_W-1:0]     nxt_count;
	logic [dit_pkg::ID_W-1:0]      nxt_last;

	assign limit   = (dit_pkg::CMP_W'(cap_q) > dit_pkg::CMP_W'(dit_pkg::MAX_ROWS))
		? dit_pkg::CMP_W'(dit_pkg::MAX_ROWS) : dit_pkg::CMP_W'(cap_q);
	assign count_x = dit_pkg::CMP_W'(count_q);
	assign step_x  = dit_pkg::CMP_W'(step_q);
	assign row_x   = dit_pkg::CMP_W'(row_q);
	assign add_ok  = count_x < limit;
	assign in_rows = step_x < count_x;
	assign is_hit  = (cmd_q == dit_pkg::CMD_REMOVE) && in_rows && !found_q && (head_id == id_q);
	assign add_slot = (cmd_q == dit_pkg::CMD_ADD) && add_ok && (step_x == count_x);
	assign last_step = step_q == dit_pkg::ROW_W'(dit_pkg::MAX_ROWS - 1);
	assign out_free = !out_valid_q || !out_stall;
	assign accept   = (state_q == S_IDLE) && in_valid;

	always_comb begin
		ring_ctl.shift   = state_q == S_RUN;
		ring_ctl.tail_id = head_id;
		if (add_slot) begin
			ring_ctl.tail_id = id_q;
		end else if (is_hit) begin
			ring_ctl.tail_id = last_q;
		end
	end

	always_comb begin
		r_status      = dit_pkg::ST_OK;
		r_moved_valid = 1'b0;
		r_moved_id    = '0;
		r_read_id     = '0;
		nxt_count     = count_q;
		nxt_last      = last_q;
		case (cmd_q)
			dit_pkg::CMD_ADD: begin
				if (add_ok) begin
					nxt_count = dit_pkg::CNT_W'(count_q + 1'b1);
					nxt_last  = id_q;
				end else begin
					r_status = dit_pkg::ST_FULL;
				end
			end
			dit_pkg::CMD_REMOVE: begin
				if (found_q) begin
					nxt_count     = dit_pkg::CNT_W'(count_q - 1'b1);
					r_moved_valid = !hit_last_q;
					r_moved_id    = hit_last_q ? '0 : last_q;
					nxt_last      = hit_prev_q ? last_q : prev_q;
				end else begin
					r_status = dit_pkg::ST_NOT_FOUND;
				end
			end
			dit_pkg::CMD_READ: begin
				if (row_x < count_x) begin
					r_read_id = read_q;
				end else begin
					r_status = dit_pkg::ST_RANGE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= dit_pkg::CAP_W'(256);
			count_q     <= '0;
			step_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RUN;
						step_q  <= '0;
						found_q <= 1'b0;
					end
				end
				S_RUN: begin
					if (is_hit) begin
						found_q <= 1'b1;
					end
					if (last_step) begin
						state_q <= S_DONE;
						step_q  <= '0;
					end else begin
						step_q <= dit_pkg::ROW_W'(step_q + 1'b1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
						count_q <= nxt_count;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= dit_pkg::cmd_t'(cmd);
			id_q  <= dit_pkg::ID_W'(entity_id);
			row_q <= row_index;
		end
		if (state_q == S_RUN) begin
			if (is_hit) begin
				hit_last_q <= (step_x + 1'b1) == count_x;
				hit_prev_q <= (step_x + 2'd2) == count_x;
			end
			if ((step_x + 2'd2) == count_x) begin
				prev_q <= head_id;
			end
			if (step_x == row_x) begin
				read_q <= head_id;
			end
		end
		if ((state_q == S_DONE) && out_free) begin
			last_q        <= nxt_last;
			status_q      <= r_status;
			moved_valid_q <= r_moved_valid;
			moved_id_q    <= r_moved_id;
			read_id_q     <= r_read_id;
			live_count_q  <= nxt_count;
			is_full_q     <= dit_pkg::CMP_W'(nxt_count) >= limit;
		end
	end

	assign in_stall    = state_q != S_IDLE;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign moved_valid = moved_valid_q;
	assign moved_id    = 32'(moved_id_q);
	assign read_id     = 32'(read_id_q);
	assign live_count  = 9'(live_count_q);
	assign is_full     = is_full_q;
endmodule
`default_nettype wire

// File: sv/dense_id_table_swap_remove.sv
// Dense ID table with swap-remove: a ring of MAX_ROWS ID cells rotated once per transaction.
// The result is registered once the ring has completed its full rotation.
// A new transaction is accepted only after the previous one completes, as the ring moves one cell per cycle.
// Reset: count 0, capacity 256, handshake idle; ID cells are not reset.
// Depends on dit_pkg, dit_cell, dit_ctrl and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dense_id_table_swap_remove (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [8:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] entity_id,
	input  logic [7:0]  row_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        moved_valid,
	output logic [31:0] moved_id,
	output logic [31:0] read_id,
	output logic [8:0]  live_count,
	output logic        is_full
);
	logic [dit_pkg::ID_W-1:0] cell_id [dit_pkg::MAX_ROWS];
	dit_pkg::ring_ctl_t       ring_ctl;

	// Cells shift toward index 0; cell 0 is the head, the tail is fed by the sequencer.
	for (genvar k = 0; k < dit_pkg::MAX_ROWS; k++) begin : g_ring
		if (k == dit_pkg::MAX_ROWS - 1) begin : g_tail
			dit_cell u_cell (
				.clk    (clk),
				.shift  (ring_ctl.shift),
				.nbr_id (ring_ctl.tail_id),
				.id     (cell_id[k])
			);
		end else begin : g_body
			dit_cell u_cell (
				.clk    (clk),
				.shift  (ring_ctl.shift),
				.nbr_id (cell_id[k+1]),
				.id     (cell_id[k])
			);
		end
	end

	dit_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (dit_pkg::CAP_W'(cfg_wr_data)),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.entity_id   (entity_id),
		.row_index   (dit_pkg::IDX_W'(row_index)),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.moved_valid (moved_valid),
		.moved_id    (moved_id),
		.read_id     (read_id),
		.live_count  (live_count),
		.is_full     (is_full),
		.head_id     (cell_id[0]),
		.ring_ctl    (ring_ctl)
	);

	`ASSERT_NEXT(a_accept_starts_ring, clk, arst_n, in_valid && !in_stall, ring_ctl.shift)
	`ASSERT_IMPL(a_no_accept_mid_ring, clk, arst_n, ring_ctl.shift, in_stall)
	`ASSERT_IMPL(a_moved_only_on_ok, clk, arst_n, out_valid && moved_valid, status == dit_pkg::ST_OK)
	`ASSERT_IMPL(a_count_in_range, clk, arst_n, out_valid, live_count <= 9'(dit_pkg::MAX_ROWS))
endmodule
`default_nettype wire
